/* hw/rtl/wfc_pkg.sv */
package wfc_pkg;

   // Table geometry
   localparam int ENTRIES  = 64;
   localparam int WORD_LEN = 16;

   localparam int SLOT_W = $clog2(ENTRIES);
   localparam int USED_W = $clog2(ENTRIES + 1);
   localparam int CIDX_W = $clog2(WORD_LEN);
   localparam int LEN_W  = $clog2(WORD_LEN + 1);

   // Fixed field widths of the channels
   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Delimiter codes and case folding constants
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_PERIOD  = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_CASE    = 8'h20;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DELIVER
   } state_type;

   // One row of the word table
   typedef struct packed {
      logic [LEN_W-1:0]                 len;
      logic [COUNT_W-1:0]               tally;
      logic [WORD_LEN-1:0][CHAR_W-1:0]  chars;
   } row_type;

   // One result item
   typedef struct packed {
      logic [INDEX_W-1:0] entry_index;
      logic [COUNT_W-1:0] word_count;
      logic               is_new;
      logic               dropped_full;
      logic               truncated;
      logic               text_done;
   } result_type;

   function automatic logic is_delim(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || (c == CH_COMMA) || (c == CH_PERIOD) ||
             (c == CH_NEWLINE) || (c == CH_TAB);
   endfunction

   function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
      return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? (c | CH_CASE) : c;
   endfunction

endpackage

/* hw/rtl/wfc_if.sv */
interface wfc_req_if import wfc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface wfc_rsp_if import wfc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] entry_index;
   logic [COUNT_W-1:0] word_count;
   logic               is_new;
   logic               dropped_full;
   logic               truncated;
   logic               text_done;

   modport source (output valid, output entry_index, output word_count, output is_new,
                   output dropped_full, output truncated, output text_done, input ready);
   modport sink   (input valid, input entry_index, input word_count, input is_new,
                   input dropped_full, input truncated, input text_done, output ready);
endinterface

/* hw/rtl/word_frequency_counter_top.sv */
// Channel    Dir  Payload                                                 Item
// req_chan   in   char_code[7:0], end_of_text                             one text byte
// rsp_chan   out  entry_index[5:0], word_count[15:0], is_new,             one finished word
//                 dropped_full, truncated, text_done
//
// A byte that ends no word is taken in ST_IDLE. A byte that finishes a word is accepted, then
// ST_SEARCH scans the stored words slot by slot (at least one slot, at most the number of stored
// words, up to 64), then ST_DELIVER hands the item to the output register once it is free.
// The scan rate is set by the single read port of the word table memory.
// Reset (synchronous, active high) empties the table and the pending word; no clearing pass.
// A stalled rsp_chan holds one finished item while the next word is read and searched.
module word_frequency_counter_top import wfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   wfc_req_if.sink    req_chan,
   wfc_rsp_if.source  rsp_chan
);

   state_type st_ff, st_in;

   logic [CHAR_W-1:0] pend_chars_ff [WORD_LEN];
   logic [LEN_W-1:0]  pend_len_ff;
   logic              pend_ovf_ff;
   logic              done_ff;
   logic [USED_W-1:0] used_ff;
   logic [SLOT_W-1:0] slot_ff;

   row_type           tbl_mem [ENTRIES];
   row_type           row_q_ff;

   result_type        res_ff, res_in;
   result_type        rsp_ff;
   logic              rsp_valid_ff;

   logic              req_ready;
   logic              accept;
   logic              c_delim;
   logic [CHAR_W-1:0] c_low;
   logic              pend_room;
   logic [LEN_W-1:0]  len_after;
   logic              finish_now;

   logic [SLOT_W-1:0] rd_addr;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   row_type           wr_row;

   logic              in_range;
   logic              match;
   logic              hit;
   logic              scan_end;
   logic              decide;
   logic              tbl_full;
   logic              insert;
   logic [COUNT_W-1:0] tally_inc;
   logic              out_free;
   logic              deliver;

   // Classify the incoming byte
   assign accept     = req_chan.valid && req_chan.ready;
   assign c_delim    = is_delim(req_chan.char_code);
   assign c_low      = fold_case(req_chan.char_code);
   assign pend_room  = pend_len_ff < LEN_W'(WORD_LEN);
   assign len_after  = (!c_delim && pend_room) ? pend_len_ff + LEN_W'(1) : pend_len_ff;
   assign finish_now = (len_after != '0) && (c_delim || req_chan.end_of_text);

   // Compare the fetched row against the pending word
   always_comb begin
      match = (row_q_ff.len == pend_len_ff);
      for (int k = 0; k < WORD_LEN; k++) begin
         if ((LEN_W'(k) < pend_len_ff) && (row_q_ff.chars[k] != pend_chars_ff[k])) begin
            match = 1'b0;
         end
      end
   end

   assign in_range  = USED_W'(slot_ff) < used_ff;
   assign hit       = in_range && match;
   assign scan_end  = (USED_W'(slot_ff) + USED_W'(1)) >= used_ff;
   assign decide    = (st_ff == ST_SEARCH) && (hit || scan_end);
   assign tbl_full  = used_ff == USED_W'(ENTRIES);
   assign insert    = decide && !hit && !tbl_full;
   assign tally_inc = (row_q_ff.tally == COUNT_MAX) ? row_q_ff.tally
                                                    : row_q_ff.tally + COUNT_W'(1);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   // Update on a hit, fill on an insert, flag a drop when the table is full
   always_comb begin
      wr_en  = 1'b0;
      wr_addr = slot_ff;
      wr_row = row_q_ff;
      res_in = res_ff;
      if (decide) begin
         res_in.truncated = pend_ovf_ff;
         res_in.text_done = done_ff;
         if (hit) begin
            wr_en                = 1'b1;
            wr_row.tally         = tally_inc;
            res_in.entry_index   = INDEX_W'(slot_ff);
            res_in.word_count    = tally_inc;
            res_in.is_new        = 1'b0;
            res_in.dropped_full  = 1'b0;
         end else if (!tbl_full) begin
            wr_en                = 1'b1;
            wr_addr              = used_ff[SLOT_W-1:0];
            wr_row.len           = pend_len_ff;
            wr_row.tally         = COUNT_W'(1);
            for (int k = 0; k < WORD_LEN; k++) begin
               wr_row.chars[k]   = pend_chars_ff[k];
            end
            res_in.entry_index   = INDEX_W'(used_ff);
            res_in.word_count    = COUNT_W'(1);
            res_in.is_new        = 1'b1;
            res_in.dropped_full  = 1'b0;
         end else begin
            res_in.entry_index   = '0;
            res_in.word_count    = '0;
            res_in.is_new        = 1'b0;
            res_in.dropped_full  = 1'b1;
         end
      end
   end

   // Next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:    if (accept && finish_now) st_in = ST_SEARCH;
         ST_SEARCH:  if (decide) st_in = ST_DELIVER;
         ST_DELIVER: if (out_free) st_in = ST_IDLE;
         default:    st_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready = 1'b0;
      rd_addr   = '0;
      deliver   = 1'b0;
      unique case (st_ff)
         ST_IDLE:    req_ready = 1'b1;
         ST_SEARCH:  rd_addr   = slot_ff + SLOT_W'(1);
         ST_DELIVER: deliver   = out_free;
         default:    req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   // Append the folded byte to the pending word
   always_ff @(posedge clock) begin
      if (accept && !c_delim && pend_room) begin
         pend_chars_ff[pend_len_ff[CIDX_W-1:0]] <= c_low;
      end
   end

   // Track pending length and overflow
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_len_ff <= '0;
         pend_ovf_ff <= 1'b0;
      end else if (accept) begin
         if (req_chan.end_of_text && !finish_now) begin
            pend_len_ff <= '0;
            pend_ovf_ff <= 1'b0;
         end else if (!c_delim) begin
            pend_len_ff <= len_after;
            if (!pend_room) begin
               pend_ovf_ff <= 1'b1;
            end
         end
      end else if (decide) begin
         pend_len_ff <= '0;
         pend_ovf_ff <= 1'b0;
      end
   end

   // Count occupied slots; end of text empties the table
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (accept && req_chan.end_of_text && !finish_now) begin
         used_ff <= '0;
      end else if (decide) begin
         if (done_ff) begin
            used_ff <= '0;
         end else if (insert) begin
            used_ff <= used_ff + USED_W'(1);
         end
      end
   end

   // Advance the scan pointer and latch end of text
   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff <= '0;
         done_ff <= req_chan.end_of_text;
      end else if ((st_ff == ST_SEARCH) && !decide) begin
         slot_ff <= slot_ff + SLOT_W'(1);
      end
   end

   // Word table memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[wr_addr] <= wr_row;
      end
      row_q_ff <= tbl_mem[rd_addr];
   end

   // Hold the finished result until the output register frees
   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (deliver) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (deliver) begin
         rsp_ff <= res_ff;
      end
   end

   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.entry_index  = rsp_ff.entry_index;
   assign rsp_chan.word_count   = rsp_ff.word_count;
   assign rsp_chan.is_new       = rsp_ff.is_new;
   assign rsp_chan.dropped_full = rsp_ff.dropped_full;
   assign rsp_chan.truncated    = rsp_ff.truncated;
   assign rsp_chan.text_done    = rsp_ff.text_done;

endmodule

/* hw/rtl/wfc_checker.sv */
module wfc_checker import wfc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [INDEX_W-1:0] rsp_entry_index,
   input logic [COUNT_W-1:0] rsp_word_count,
   input logic               rsp_is_new,
   input logic               rsp_dropped_full
);

   // Hold a stalled item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_index) &&
                                  $stable(rsp_word_count) && $stable(rsp_is_new))
      else $error("stalled result item changed");

   // Drop a word only with zeroed slot and count
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped_full |->
         (rsp_entry_index == '0) && (rsp_word_count == '0) && !rsp_is_new)
      else $error("dropped word carries slot or count");

   // Start a new entry at count one
   a_new_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_new |-> (rsp_word_count == COUNT_W'(1)) && !rsp_dropped_full)
      else $error("new entry count is not one");

   // Never report a zero count for a stored word
   a_count_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_dropped_full |-> rsp_word_count != '0)
      else $error("stored word with zero count");

   // Clear the output after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind word_frequency_counter_top wfc_checker u_wfc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_entry_index  (rsp_chan.entry_index),
   .rsp_word_count   (rsp_chan.word_count),
   .rsp_is_new       (rsp_chan.is_new),
   .rsp_dropped_full (rsp_chan.dropped_full)
);

/* tb/word_frequency_counter_top_tb.sv */
`timescale 1ns / 1ps

module word_frequency_counter_top_tb;
   import wfc_pkg::*;

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 10;
   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int RANDOM_ITEMS  = 800;
   localparam int DRAIN_LIMIT   = 50_000;
   localparam int SETTLE_CYCLES = 100;

   // Plain text bytes used to build words
   localparam logic [CHAR_W-1:0] LOWER_A  = 8'h61;
   localparam logic [CHAR_W-1:0] LOWER_Q  = 8'h71;
   localparam logic [CHAR_W-1:0] LOWER_X  = 8'h78;
   localparam logic [CHAR_W-1:0] BYTE_ZERO = 8'h00;
   localparam logic [CHAR_W-1:0] BYTE_ONES = 8'hFF;
   localparam logic [CHAR_W-1:0] BELOW_A  = 8'h40;
   localparam logic [CHAR_W-1:0] ABOVE_Z  = 8'h5B;

   localparam logic [CHAR_W-1:0] SEPARATORS [5] =
      '{CH_SPACE, CH_COMMA, CH_PERIOD, CH_NEWLINE, CH_TAB};

   // Results that can be read straight off the text
   localparam result_type NO_RESULT  = '0;
   localparam result_type FIRST_WORD = '{entry_index: '0, word_count: 16'd1, is_new: 1'b1,
                                         dropped_full: 1'b0, truncated: 1'b0,
                                         text_done: 1'b0};
   localparam result_type LONG_FIRST = '{entry_index: '0, word_count: 16'd1, is_new: 1'b1,
                                         dropped_full: 1'b0, truncated: 1'b1,
                                         text_done: 1'b1};

   typedef struct {
      logic [CHAR_W-1:0] char_code;
      logic              end_of_text;
      int                reps;
      bit                has_typed;
      result_type        typed;
   } text_row_type;

   localparam int DIRECTED_ROWS = 16;

   // Directed text: case folding edges, odd bytes, repeated separators,
   // end of text on a letter, on a separator and with nothing pending, long word
   text_row_type directed_rows [DIRECTED_ROWS] = '{
      '{CH_UPPER_A, 1'b0,  1, 1'b0, NO_RESULT},
      '{CH_SPACE,   1'b0,  1, 1'b1, FIRST_WORD},
      '{BYTE_ZERO,  1'b0,  1, 1'b0, NO_RESULT},
      '{BYTE_ONES,  1'b0,  1, 1'b0, NO_RESULT},
      '{BELOW_A,    1'b0,  1, 1'b0, NO_RESULT},
      '{ABOVE_Z,    1'b0,  1, 1'b0, NO_RESULT},
      '{CH_COMMA,   1'b0,  1, 1'b0, NO_RESULT},
      '{CH_PERIOD,  1'b0,  1, 1'b0, NO_RESULT},
      '{LOWER_A,    1'b0,  1, 1'b0, NO_RESULT},
      '{CH_TAB,     1'b0,  1, 1'b0, NO_RESULT},
      '{CH_UPPER_Z, 1'b0,  1, 1'b0, NO_RESULT},
      '{CH_UPPER_Z, 1'b1,  1, 1'b0, NO_RESULT},
      '{CH_NEWLINE, 1'b1,  1, 1'b0, NO_RESULT},
      '{LOWER_X,    1'b0, 17, 1'b0, NO_RESULT},
      '{CH_SPACE,   1'b1,  1, 1'b1, LONG_FIRST},
      '{CH_PERIOD,  1'b1,  1, 1'b0, NO_RESULT}
   };

   logic clock;
   logic reset;

   wfc_req_if req_chan ();
   wfc_rsp_if rsp_chan ();

   word_frequency_counter_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Word table mirror
   logic [CHAR_W-1:0]  word_chars [WORD_LEN];
   int                 word_len = 0;
   bit                 word_long = 1'b0;
   logic [CHAR_W-1:0]  dict_chars [ENTRIES][WORD_LEN];
   int                 dict_len [ENTRIES];
   logic [COUNT_W-1:0] dict_tally [ENTRIES];
   int                 dict_used = 0;

   result_type        expected_words [$];
   logic [CHAR_W-1:0] text_bytes [$];

   bit         item_has_typed = 1'b0;
   result_type item_typed_rsp = '0;
   int         queued_before;
   result_type want;
   int         mismatches = 0;
   int         cycle_count = 0;
   int         random_items = 0;
   int         sender_idle_pct = 0;
   int         receiver_idle_pct = 0;

   function automatic bit is_separator(logic [CHAR_W-1:0] c);
      return c inside {CH_SPACE, CH_COMMA, CH_PERIOD, CH_NEWLINE, CH_TAB};
   endfunction

   // Look up the pending word, bump or insert it, and clear the pending word
   function automatic result_type close_word(bit done);
      result_type r;
      int  s;
      int  k;
      int  slot;
      bit  found;
      bit  same;
      r = '0;
      slot = 0;
      found = 1'b0;
      for (s = 0; s < dict_used && !found; s++) begin
         same = (dict_len[s] == word_len);
         for (k = 0; k < word_len && same; k++)
            same = (dict_chars[s][k] == word_chars[k]);
         if (same) begin
            found = 1'b1;
            slot = s;
         end
      end
      if (found) begin
         if (dict_tally[slot] != COUNT_MAX)
            dict_tally[slot] = dict_tally[slot] + COUNT_W'(1);
         r.entry_index = INDEX_W'(slot);
         r.word_count = dict_tally[slot];
      end else if (dict_used < ENTRIES) begin
         slot = dict_used;
         for (k = 0; k < word_len; k++)
            dict_chars[slot][k] = word_chars[k];
         dict_len[slot] = word_len;
         dict_tally[slot] = COUNT_W'(1);
         dict_used++;
         r.entry_index = INDEX_W'(slot);
         r.word_count = COUNT_W'(1);
         r.is_new = 1'b1;
      end else begin
         r.dropped_full = 1'b1;
      end
      r.truncated = word_long;
      r.text_done = done;
      word_len = 0;
      word_long = 1'b0;
      return r;
   endfunction

   // Advance the mirror by one byte and queue the word it finishes, if any
   function automatic void tally_byte(logic [CHAR_W-1:0] c, logic eot);
      logic [CHAR_W-1:0] folded;
      bit produced;
      produced = 1'b0;
      if (is_separator(c)) begin
         if (word_len > 0) begin
            expected_words.push_back(close_word(eot));
            produced = 1'b1;
         end
      end else begin
         folded = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c + CH_CASE) : c;
         if (word_len < WORD_LEN) begin
            word_chars[word_len] = folded;
            word_len++;
         end else begin
            word_long = 1'b1;
         end
      end
      if (eot) begin
         if (!produced && word_len > 0)
            expected_words.push_back(close_word(1'b1));
         word_len = 0;
         word_long = 1'b0;
         dict_used = 0;
      end
   endfunction

   function automatic void check_field(string field, logic [31:0] exp_val,
                                       logic [31:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s: expected %0d, actual %0d", field, exp_val, got_val);
         mismatches++;
      end
   endfunction

   // Random letter case on a lower-case letter
   function automatic void put_letter(logic [CHAR_W-1:0] lower);
      text_bytes.push_back(($urandom_range(0, 3) == 0) ? (lower - CH_CASE) : lower);
   endfunction

   // Spell a word id in base 26; a long word shares its first WORD_LEN bytes
   function automatic void put_word(int id, bit long_word);
      int start;
      int tail;
      start = text_bytes.size();
      do begin
         put_letter(CHAR_W'(LOWER_A + id % 26));
         id = id / 26;
      end while (id > 0);
      if (long_word) begin
         while (text_bytes.size() - start < WORD_LEN)
            put_letter(LOWER_Q);
         tail = $urandom_range(0, 4);
         repeat (tail) put_letter(CHAR_W'(LOWER_A + $urandom_range(0, 25)));
      end
   endfunction

   function automatic void put_separators();
      repeat (($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1)
         text_bytes.push_back(SEPARATORS[$urandom_range(0, 4)]);
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver stalls
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // Predict on every accepted byte
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         queued_before = expected_words.size();
         tally_byte(req_chan.char_code, req_chan.end_of_text);
         if (item_has_typed) begin
            if (expected_words.size() > queued_before)
               void'(expected_words.pop_back());
            expected_words.push_back(item_typed_rsp);
         end
      end
   end

   // Compare every accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result item: entry_index %0d, word_count %0d",
                   rsp_chan.entry_index, rsp_chan.word_count);
            mismatches++;
         end else begin
            want = expected_words.pop_front();
            check_field("entry_index", 32'(want.entry_index), 32'(rsp_chan.entry_index));
            check_field("word_count", 32'(want.word_count), 32'(rsp_chan.word_count));
            check_field("is_new", 32'(want.is_new), 32'(rsp_chan.is_new));
            check_field("dropped_full", 32'(want.dropped_full),
                        32'(rsp_chan.dropped_full));
            check_field("truncated", 32'(want.truncated), 32'(rsp_chan.truncated));
            check_field("text_done", 32'(want.text_done), 32'(rsp_chan.text_done));
         end
      end
   end

   // Offer one byte after a random gap and hold it until accepted
   task automatic send_byte(input logic [CHAR_W-1:0] c, input logic eot,
                            input bit has_typed = 1'b0, input result_type typed = '0);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.char_code   <= c;
      req_chan.end_of_text <= eot;
      item_has_typed       <= has_typed;
      item_typed_rsp       <= typed;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Send the built text with end of text on its last byte
   task automatic send_text();
      int i;
      for (i = 0; i < text_bytes.size(); i++)
         send_byte(text_bytes[i], i == text_bytes.size() - 1);
      text_bytes.delete();
   endtask

   // Hold the sender until every expected result has come or DRAIN_LIMIT runs out
   task automatic wait_for_results();
      int waited;
      req_chan.valid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // Build one random text: mostly sentences over a small vocabulary,
   // sometimes one that overfills the table, sometimes raw noise
   task automatic make_random_text();
      int kind;
      int n;
      int w;
      int vocab;
      int base;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         n = $urandom_range(4, 40);
         repeat (n) begin
            if ($urandom_range(0, 3) == 0)
               text_bytes.push_back(SEPARATORS[$urandom_range(0, 4)]);
            else
               text_bytes.push_back(CHAR_W'($urandom_range(0, 255)));
         end
      end else if (kind == 1) begin
         n = ENTRIES + $urandom_range(1, 6);
         for (w = 0; w < n; w++) begin
            put_word(w, 1'b0);
            put_separators();
         end
         repeat ($urandom_range(1, 5)) begin
            put_word($urandom_range(0, n + 3), 1'b0);
            put_separators();
         end
      end else begin
         vocab = $urandom_range(1, 12);
         base = $urandom_range(0, 600);
         n = $urandom_range(3, 25);
         repeat (n) begin
            put_word(base + $urandom_range(0, vocab - 1), $urandom_range(0, 9) == 0);
            put_separators();
         end
      end
      // Vary where the end of text lands
      case ($urandom_range(0, 2))
         0: begin
            while (text_bytes.size() > 1 && is_separator(text_bytes[$]))
               void'(text_bytes.pop_back());
         end
         1: begin
         end
         default: begin
            text_bytes.push_back(SEPARATORS[$urandom_range(0, 4)]);
         end
      endcase
   endtask

   task automatic run_random(input int goal);
      while (random_items < goal) begin
         make_random_text();
         random_items += text_bytes.size();
         send_text();
      end
   endtask

   // Main sequence
   initial begin
      int r;
      int n;
      int w;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.char_code   = '0;
      req_chan.end_of_text = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Sender idles a little, receiver a lot
      sender_idle_pct   = 23;
      receiver_idle_pct = 76;
      for (r = 0; r < DIRECTED_ROWS; r++) begin
         for (n = 1; n <= directed_rows[r].reps; n++)
            send_byte(directed_rows[r].char_code, directed_rows[r].end_of_text,
                      directed_rows[r].has_typed && n == directed_rows[r].reps,
                      directed_rows[r].typed);
      end

      // Fill every slot, then drop one word
      for (w = 0; w <= ENTRIES; w++) begin
         put_word(w, 1'b0);
         text_bytes.push_back(CH_SPACE);
      end
      send_text();

      run_random(RANDOM_ITEMS / 3);
      wait_for_results();

      // Sender idles a lot, receiver a little
      sender_idle_pct   = 76;
      receiver_idle_pct = 23;
      run_random(2 * RANDOM_ITEMS / 3);
      wait_for_results();

      // No idling on either side
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      run_random(RANDOM_ITEMS);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_words.size() != 0) begin
         $error("%0d expected result items never arrived", expected_words.size());
         mismatches++;
      end

      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* word_frequency_counter_top.f */
hw/rtl/wfc_pkg.sv
hw/rtl/wfc_if.sv
hw/rtl/word_frequency_counter_top.sv
hw/rtl/wfc_checker.sv
tb/word_frequency_counter_top_tb.sv
